/* rtl/rlrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rlrc_pkg;

  // Row lengths of the cell chain
  localparam int SQR_CELLS = 32;  // floor sqrt of the 64-bit squared norm
  localparam int DIV_CELLS = 33;  // Q1.32 ratio, one quotient bit per cell
  localparam int SQW_CELLS = 17;  // floor sqrt of the 33-bit ratio
  localparam int LOG_CELLS = 30;  // log2 fraction bits, one per cell

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [16:0]        weight;
    logic [47:0]        loss_value;
    logic               discarded;
  } out_t;

  // Digit-by-digit square root state
  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_t;

  // Restoring divider state
  typedef struct packed {
    logic [49:0] rem;
    logic        nb;
    logic [49:0] den;
    logic [32:0] q;
  } dv_t;

  // Two log2 operands: normalised value, shift count, mantissa, fraction
  typedef struct packed {
    logic [49:0] vd;
    logic [49:0] vb;
    logic [5:0]  cd;
    logic [5:0]  cb;
    logic [30:0] md;
    logic [30:0] mb;
    logic [29:0] fd;
    logic [29:0] fb;
  } lg_t;

  // Everything one residual carries along the chain
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [47:0]        s;
    logic [49:0]        d;
    logic [31:0]        r;
    logic [16:0]        qs;
    sq_t                sq;
    dv_t                dv;
    lg_t                lg;
  } ctx_t;

endpackage

`default_nettype wire

/* rtl/rlrc_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlrc_sqrt_cell import rlrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  ctx_t in_c,
  output logic out_v,
  output ctx_t out_c
);

  ctx_t        nxt;
  logic [35:0] acc;
  logic [35:0] trial;

  // One root digit; also shift each log operand one place towards bit 49 unless its bit 49 is set
  always_comb begin
    nxt = in_c;
    acc = {in_c.sq.rem, in_c.sq.rad[63:62]};
    trial = {2'b00, in_c.sq.root, 2'b01};
    nxt.sq.rad = {in_c.sq.rad[61:0], 2'b00};
    if (acc >= trial) begin
      nxt.sq.rem = 34'(acc - trial);
      nxt.sq.root = {in_c.sq.root[30:0], 1'b1};
    end else begin
      nxt.sq.rem = acc[33:0];
      nxt.sq.root = {in_c.sq.root[30:0], 1'b0};
    end
    if (!in_c.lg.vd[49]) begin
      nxt.lg.vd = {in_c.lg.vd[48:0], 1'b0};
      nxt.lg.cd = in_c.lg.cd + 6'd1;
    end
    if (!in_c.lg.vb[49]) begin
      nxt.lg.vb = {in_c.lg.vb[48:0], 1'b0};
      nxt.lg.cb = in_c.lg.cb + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rlrc_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlrc_div_cell import rlrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  ctx_t in_c,
  output logic out_v,
  output ctx_t out_c
);

  ctx_t        nxt;
  logic [50:0] acc;

  // One restoring quotient bit
  always_comb begin
    nxt = in_c;
    acc = {in_c.dv.rem, in_c.dv.nb};
    nxt.dv.nb = 1'b0;
    if (acc >= {1'b0, in_c.dv.den}) begin
      nxt.dv.rem = 50'(acc - {1'b0, in_c.dv.den});
      nxt.dv.q = {in_c.dv.q[31:0], 1'b1};
    end else begin
      nxt.dv.rem = acc[49:0];
      nxt.dv.q = {in_c.dv.q[31:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rlrc_log_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlrc_log_cell import rlrc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_v,
  input  ctx_t in_c,
  output logic out_v,
  output ctx_t out_c
);

  ctx_t        nxt;
  logic [61:0] sqd;
  logic [61:0] sqb;
  logic [31:0] td;
  logic [31:0] tb;

  // Square both mantissas; a carry into bit 31 yields a fraction bit of one
  always_comb begin
    nxt = in_c;
    sqd = {31'b0, in_c.lg.md} * {31'b0, in_c.lg.md};
    sqb = {31'b0, in_c.lg.mb} * {31'b0, in_c.lg.mb};
    td = sqd[61:30];
    tb = sqb[61:30];
    if (td[31]) begin
      nxt.lg.md = td[31:1];
      nxt.lg.fd = {in_c.lg.fd[28:0], 1'b1};
    end else begin
      nxt.lg.md = td[30:0];
      nxt.lg.fd = {in_c.lg.fd[28:0], 1'b0};
    end
    if (tb[31]) begin
      nxt.lg.mb = tb[31:1];
      nxt.lg.fb = {in_c.lg.fb[28:0], 1'b1};
    end else begin
      nxt.lg.mb = tb[30:0];
      nxt.lg.fb = {in_c.lg.fb[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/robust_loss_residual_correction_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Robust-loss reweighting of 2-D residuals (Huber or Cauchy). One residual
// beat is taken every cycle while item_ready is high, and one result beat
// leaves per residual, in order. The chain of cells is: stage 0 and stage 1
// for the squared norm, 32 root cells for sqrt(s), 33 divider cells for the
// Q1.32 ratio, 17 root cells for the weight, 30 log2 cells for the Cauchy
// loss, the F1 to F4 registers and the output register. A skid stage behind
// the output register lets a residual beat be taken while a result waits;
// item_ready falls only once that skid stage is full. Configuration writes
// are accepted every cycle and must only be issued while the block is idle.

module robust_loss_residual_correction_core import rlrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_t         item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_t        result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam logic [1:0]  REG_LOSS_KIND = 2'd0;
  localparam logic [1:0]  REG_HUBER_A   = 2'd1;
  localparam logic [1:0]  REG_SCALE_B   = 2'd2;
  localparam logic [1:0]  REG_MAX_ERROR = 2'd3;
  localparam logic        KIND_HUBER    = 1'b0;
  localparam logic [47:0] MASK48        = 48'hFFFF_FFFF_FFFF;
  localparam logic [29:0] LN2_Q30       = 30'd744261118;
  localparam logic [16:0] W_ONE         = 17'd65536;

  // Configuration registers
  logic        loss_kind;
  logic [31:0] huber_a;
  logic [47:0] scale_b;
  logic [47:0] max_error;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      loss_kind <= 1'b0;
      huber_a <= 32'd65536;
      scale_b <= 48'd65536;
      max_error <= MASK48;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOSS_KIND: loss_kind <= cfg_data[0];
        REG_HUBER_A:   huber_a <= cfg_data[31:0];
        REG_SCALE_B:   scale_b <= cfg_data;
        REG_MAX_ERROR: max_error <= cfg_data;
        default: ;
      endcase
    end
  end

  // Whole chain advances together; hold only while the skid beat is parked
  logic en;
  logic skid_valid;
  out_t skid;

  assign en = !skid_valid;
  assign item_ready = en;

  // Stage 0: magnitudes squared
  logic               s0_v;
  logic signed [31:0] s0_x;
  logic signed [31:0] s0_y;
  logic [63:0]        s0_pxx;
  logic [63:0]        s0_pyy;
  logic [31:0]        ax;
  logic [31:0]        ay;

  assign ax = item.res_x[31] ? 32'(-item.res_x) : item.res_x;
  assign ay = item.res_y[31] ? 32'(-item.res_y) : item.res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x <= item.res_x;
      s0_y <= item.res_y;
      s0_pxx <= {32'b0, ax} * {32'b0, ax};
      s0_pyy <= {32'b0, ay} * {32'b0, ay};
    end
  end

  // Stage 1: squared norm, and b + s in one three-input add
  logic        s1_v;
  ctx_t        s1_c;
  ctx_t        s1_next;
  logic [63:0] s32;
  logic [64:0] dsum;

  always_comb begin
    s32 = s0_pxx + s0_pyy;
    dsum = {1'b0, scale_b, 16'b0} + {1'b0, s0_pxx} + {1'b0, s0_pyy};
    s1_next = '0;
    s1_next.x = s0_x;
    s1_next.y = s0_y;
    s1_next.s = s32[63:16];
    s1_next.d = {1'b0, dsum[64:16]};
    s1_next.sq.rad = s32;
    s1_next.lg.vd = {1'b0, dsum[64:16]};
    s1_next.lg.vb = {2'b00, scale_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_c <= s1_next;
    end
  end

  // Root of s32 (also normalises the log operands)
  ctx_t sr_c [0:SQR_CELLS];
  logic sr_v [0:SQR_CELLS];
  assign sr_c[0] = s1_c;
  assign sr_v[0] = s1_v;

  for (genvar i = 0; i < SQR_CELLS; i++) begin : g_sqr
    rlrc_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(sr_v[i]), .in_c(sr_c[i]),
      .out_v(sr_v[i+1]), .out_c(sr_c[i+1])
    );
  end

  // Pick numerator and denominator of the ratio: a / r or b / (b + s)
  ctx_t        t1;
  logic [47:0] num;
  logic [49:0] den;

  always_comb begin
    t1 = sr_c[SQR_CELLS];
    t1.r = t1.sq.root;
    if (loss_kind == KIND_HUBER) begin
      num = {16'b0, huber_a};
      den = (t1.sq.root == 32'd0) ? 50'd1 : {18'b0, t1.sq.root};
    end else begin
      num = scale_b;
      den = (scale_b == 48'd0) ? 50'd1 : t1.d;
    end
    t1.dv.rem = {3'b000, num[47:1]};
    t1.dv.nb = num[0];
    t1.dv.den = den;
    t1.dv.q = '0;
  end

  ctx_t dv_c [0:DIV_CELLS];
  logic dv_v [0:DIV_CELLS];
  assign dv_c[0] = t1;
  assign dv_v[0] = sr_v[SQR_CELLS];

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    rlrc_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(dv_v[i]), .in_c(dv_c[i]),
      .out_v(dv_v[i+1]), .out_c(dv_c[i+1])
    );
  end

  // Root of the ratio: place q at the top so 17 digits finish it
  ctx_t t2;

  always_comb begin
    t2 = dv_c[DIV_CELLS];
    t2.sq.rad = {1'b0, t2.dv.q, 30'b0};
    t2.sq.rem = '0;
    t2.sq.root = '0;
  end

  ctx_t qw_c [0:SQW_CELLS];
  logic qw_v [0:SQW_CELLS];
  assign qw_c[0] = t2;
  assign qw_v[0] = dv_v[DIV_CELLS];

  for (genvar i = 0; i < SQW_CELLS; i++) begin : g_sqw
    rlrc_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(qw_v[i]), .in_c(qw_c[i]),
      .out_v(qw_v[i+1]), .out_c(qw_c[i+1])
    );
  end

  // Load the Q1.30 mantissas of the normalised operands
  ctx_t t3;

  always_comb begin
    t3 = qw_c[SQW_CELLS];
    t3.qs = t3.sq.root[16:0];
    t3.lg.md = t3.lg.vd[49:19];
    t3.lg.mb = t3.lg.vb[49:19];
    t3.lg.fd = '0;
    t3.lg.fb = '0;
  end

  ctx_t lg_c [0:LOG_CELLS];
  logic lg_v [0:LOG_CELLS];
  assign lg_c[0] = t3;
  assign lg_v[0] = qw_v[SQW_CELLS];

  for (genvar i = 0; i < LOG_CELLS; i++) begin : g_log
    rlrc_log_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(lg_v[i]), .in_c(lg_c[i]),
      .out_v(lg_v[i+1]), .out_c(lg_c[i+1])
    );
  end

  // F1: discard test, weight selection, log2 difference
  ctx_t        lc;
  logic        f1_disc_next;
  logic        f1_knee_next;
  logic [16:0] f1_w_next;
  logic [35:0] f1_dl_next;

  assign lc = lg_c[LOG_CELLS];

  always_comb begin
    f1_disc_next = lc.s > max_error;
    f1_knee_next = lc.s > scale_b;
    if (f1_disc_next) begin
      f1_w_next = '0;
    end else if (loss_kind == KIND_HUBER) begin
      if (!f1_knee_next || (huber_a >= lc.r) || (lc.r == 32'd0)) begin
        f1_w_next = W_ONE;
      end else begin
        f1_w_next = lc.qs;
      end
    end else if (scale_b == 48'd0) begin
      f1_w_next = '0;
    end else begin
      f1_w_next = lc.qs;
    end
    f1_dl_next = {6'(6'd49 - lc.lg.cd), lc.lg.fd} - {6'(6'd49 - lc.lg.cb), lc.lg.fb};
  end

  logic               f1_v;
  logic signed [31:0] f1_x;
  logic signed [31:0] f1_y;
  logic [16:0]        f1_w;
  logic [35:0]        f1_dl;
  logic [31:0]        f1_r;
  logic [47:0]        f1_s;
  logic               f1_disc;
  logic               f1_knee;

  // F2: multipliers
  logic               f2_v;
  logic signed [49:0] f2_px;
  logic signed [49:0] f2_py;
  logic [16:0]        f2_w;
  logic [61:0]        f2_pl;
  logic [63:0]        f2_ph;
  logic [47:0]        f2_s;
  logic               f2_disc;
  logic               f2_knee;

  // F3: shifts, Huber loss
  logic               f3_v;
  logic signed [31:0] f3_ox;
  logic signed [31:0] f3_oy;
  logic [16:0]        f3_w;
  logic [21:0]        f3_ln;
  logic [47:0]        f3_hl;
  logic [47:0]        f3_s;
  logic               f3_disc;
  logic               f3_knee;
  logic [48:0]        hub_t;
  logic [48:0]        hub_l;

  // F4: Cauchy loss product
  logic               f4_v;
  logic signed [31:0] f4_ox;
  logic signed [31:0] f4_oy;
  logic [16:0]        f4_w;
  logic [69:0]        f4_pc;
  logic [47:0]        f4_hl;
  logic [47:0]        f4_s;
  logic               f4_disc;
  logic               f4_knee;

  always_comb begin
    hub_t = f2_ph[63:15];
    hub_l = (hub_t > {1'b0, scale_b}) ? 49'(hub_t - {1'b0, scale_b}) : 49'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
      f2_v <= 1'b0;
      f3_v <= 1'b0;
      f4_v <= 1'b0;
    end else if (en) begin
      f1_v <= lg_v[LOG_CELLS];
      f2_v <= f1_v;
      f3_v <= f2_v;
      f4_v <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_x <= lc.x;
      f1_y <= lc.y;
      f1_w <= f1_w_next;
      f1_dl <= f1_dl_next;
      f1_r <= lc.r;
      f1_s <= lc.s;
      f1_disc <= f1_disc_next;
      f1_knee <= f1_knee_next;

      f2_px <= f1_x * $signed({1'b0, f1_w});
      f2_py <= f1_y * $signed({1'b0, f1_w});
      f2_w <= f1_w;
      f2_pl <= {30'b0, f1_dl[35:4]} * {32'b0, LN2_Q30};
      f2_ph <= {32'b0, huber_a} * {32'b0, f1_r};
      f2_s <= f1_s;
      f2_disc <= f1_disc;
      f2_knee <= f1_knee;

      // floor towards minus infinity is an arithmetic shift
      f3_ox <= f2_px[47:16];
      f3_oy <= f2_py[47:16];
      f3_w <= f2_w;
      f3_ln <= f2_pl[61:40];
      f3_hl <= hub_l[48] ? MASK48 : hub_l[47:0];
      f3_s <= f2_s;
      f3_disc <= f2_disc;
      f3_knee <= f2_knee;

      f4_ox <= f3_ox;
      f4_oy <= f3_oy;
      f4_w <= f3_w;
      f4_pc <= {22'b0, scale_b} * {48'b0, f3_ln};
      f4_hl <= f3_hl;
      f4_s <= f3_s;
      f4_disc <= f3_disc;
      f4_knee <= f3_knee;
    end
  end

  // Final loss selection
  out_t fin;

  always_comb begin
    fin.out_x = f4_ox;
    fin.out_y = f4_oy;
    fin.weight = f4_w;
    fin.discarded = f4_disc;
    if (f4_disc) begin
      fin.loss_value = '0;
    end else if (loss_kind == KIND_HUBER) begin
      fin.loss_value = f4_knee ? f4_hl : f4_s;
    end else if (scale_b == 48'd0) begin
      fin.loss_value = '0;
    end else if (f4_pc[69:64] != 6'd0) begin
      fin.loss_value = MASK48;
    end else begin
      fin.loss_value = f4_pc[63:16];
    end
  end

  // Output register with skid stage: park the beat when the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        result_valid <= f4_v;
      end
    end else if (f4_v && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= skid_valid ? skid : fin;
    end else if (en) begin
      skid <= fin;
    end
  end

  // Checks
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid beat held with output register empty");

  a_discard_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.discarded) |->
      (result.weight == 17'd0 && result.loss_value == 48'd0 &&
       result.out_x == 32'sd0 && result.out_y == 32'sd0))
    else $error("discarded residual with non-zero outputs");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.weight <= W_ONE))
    else $error("weight above one");

  a_ready_after_skid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready && f4_v && en) |=> !item_ready)
    else $error("input taken with skid stage full");

endmodule

`default_nettype wire
